FILE: hw/rtl/tga_rle_pkg.sv
// ============================================================================
// tga_rle_pkg
// Shared types and constants for the Targa run-length pixel decoder.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

package tga_rle_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned BPP_W   = 3;
    localparam int unsigned TOTAL_W = 25;
    localparam int unsigned SLOT_W  = 2;
    localparam int unsigned ADDR_W  = 3;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned Q_DEPTH = 2;
    localparam int unsigned Q_PTR_W = $clog2(Q_DEPTH);
    localparam int unsigned Q_CNT_W = $clog2(Q_DEPTH + 1);

    localparam logic [TOTAL_W-1:0] MAX_PIXELS  = 25'd16777216;
    localparam logic [BYTE_W-1:0]  RUN_BIAS    = 8'd127;
    localparam logic [BPP_W-1:0]   BPP_ALPHA   = 3'd4;
    localparam logic [BPP_W-1:0]   BPP_RESET   = 3'd3;
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 25'd1;
    localparam logic [SLOT_W-1:0]  SLOT_RED    = 2'd2;
    localparam logic [SLOT_W-1:0]  SLOT_ALPHA  = 2'd3;

    typedef enum logic [0:0] {
        REG_BYTES_PER_PIXEL = 1'b0,
        REG_PIXEL_TOTAL     = 1'b1
    } tga_rle_reg_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              frame_start;
        logic              is_run;
        logic [BYTE_W-1:0] count;
    } tga_rle_entry_t;

endpackage

`default_nettype wire

FILE: hw/rtl/tga_rle_if.sv
// ============================================================================
// tga_rle_if
// Valid/ready channels for the compressed byte stream and decoded pixels.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

interface tga_rle_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       frame_start;

    modport source (output valid, output data_byte, output frame_start, input ready);
    modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tga_rle_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_res;
    logic       image_done;
    logic       truncated;

    modport source (output valid, output red, output green, output blue, output alpha,
                    output repeat_res, output image_done, output truncated, input ready);
    modport sink   (input valid, input red, input green, input blue, input alpha,
                    input repeat_res, input image_done, input truncated, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/tga_rle_front.sv
// ============================================================================
// tga_rle_front
// Accepts stream bytes, precomputes the packet header decode and holds them
// in a two-entry queue for the decode stage.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_front (
    input  wire                         clk,
    input  wire                         rst_n,
    tga_rle_byte_if.sink                byte_in,
    output logic                        q_valid,
    output tga_rle_pkg::tga_rle_entry_t q_entry,
    input  wire                         q_pop
);
    import tga_rle_pkg::*;

    tga_rle_entry_t        entry_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0]    wr_ptr_reg;
    logic [Q_PTR_W-1:0]    wr_ptr_next;
    logic [Q_PTR_W-1:0]    rd_ptr_reg;
    logic [Q_PTR_W-1:0]    rd_ptr_next;
    logic [Q_CNT_W-1:0]    cnt_reg;
    logic [Q_CNT_W-1:0]    cnt_next;
    logic                  push;
    logic                  pop;
    tga_rle_entry_t        new_entry;

    always_comb
    begin
        new_entry.data_byte   = byte_in.data_byte;
        new_entry.frame_start = byte_in.frame_start;
        new_entry.is_run      = byte_in.data_byte[BYTE_W-1];
        if (byte_in.data_byte[BYTE_W-1])
        begin
            new_entry.count = byte_in.data_byte - RUN_BIAS;
        end
        else
        begin
            new_entry.count = byte_in.data_byte + 8'd1;
        end
    end

    assign byte_in.ready = (cnt_reg != Q_CNT_W'(Q_DEPTH));
    assign push          = byte_in.valid && byte_in.ready;
    assign q_valid       = (cnt_reg != '0);
    assign pop           = q_pop && q_valid;
    assign q_entry       = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/tga_rle_back.sv
// ============================================================================
// tga_rle_back
// Walks the packet and pixel byte sequence, counts image pixels and loads
// each completed pixel into the output register.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_back (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  q_valid,
    input  tga_rle_pkg::tga_rle_entry_t          q_entry,
    output logic                                 q_pop,
    input  wire [tga_rle_pkg::BPP_W-1:0]         bytes_per_pixel,
    input  wire [tga_rle_pkg::TOTAL_W-1:0]       pixel_total,
    tga_rle_pix_if.source                        pix_out
);
    import tga_rle_pkg::*;

    logic                 in_pixel_reg, in_pixel_next;
    logic                 is_run_reg, is_run_next;
    logic [BYTE_W-1:0]    left_reg, left_next;
    logic [SLOT_W-1:0]    slot_reg, slot_next;
    logic [BYTE_W-1:0]    blue_reg, blue_next;
    logic [BYTE_W-1:0]    green_reg, green_next;
    logic [BYTE_W-1:0]    red_reg, red_next;
    logic [TOTAL_W-1:0]   done_reg, done_next;
    logic                 out_valid_reg, out_valid_next;

    logic [BYTE_W-1:0]    o_red_reg, o_green_reg, o_blue_reg, o_alpha_reg, o_rep_reg;
    logic                 o_done_reg, o_trunc_reg;

    logic                 e_in_pixel, e_is_run;
    logic [BYTE_W-1:0]    e_left, e_blue, e_green, e_red;
    logic [SLOT_W-1:0]    e_slot;
    logic [TOTAL_W-1:0]   e_done;
    logic                 four;
    logic [SLOT_W-1:0]    last_slot;
    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W-1:0]   remaining;
    logic                 clamp;
    logic                 emit;
    logic [BYTE_W-1:0]    pix_red, pix_alpha, rep;
    logic                 trunc;
    logic                 can_go;
    logic [BYTE_W-1:0]    b;

    assign can_go = !out_valid_reg || pix_out.ready;
    assign q_pop  = q_valid && can_go;
    assign b      = q_entry.data_byte;

    always_comb
    begin
        e_in_pixel = q_entry.frame_start ? 1'b0 : in_pixel_reg;
        e_is_run   = q_entry.frame_start ? 1'b0 : is_run_reg;
        e_left     = q_entry.frame_start ? '0 : left_reg;
        e_slot     = q_entry.frame_start ? '0 : slot_reg;
        e_blue     = q_entry.frame_start ? '0 : blue_reg;
        e_green    = q_entry.frame_start ? '0 : green_reg;
        e_red      = q_entry.frame_start ? '0 : red_reg;
        e_done     = q_entry.frame_start ? '0 : done_reg;

        four      = (bytes_per_pixel == BPP_ALPHA);
        last_slot = four ? SLOT_ALPHA : SLOT_RED;
        total     = (pixel_total > MAX_PIXELS) ? MAX_PIXELS : pixel_total;
        remaining = total - e_done;
        clamp     = {{(TOTAL_W-BYTE_W){1'b0}}, e_left} > remaining;

        in_pixel_next = e_in_pixel;
        is_run_next   = e_is_run;
        left_next     = e_left;
        slot_next     = e_slot;
        blue_next     = e_blue;
        green_next    = e_green;
        red_next      = e_red;
        done_next     = e_done;
        emit          = 1'b0;
        pix_red       = e_red;
        pix_alpha     = '0;
        rep           = 8'd1;
        trunc         = 1'b0;

        if (e_done >= total)
        begin
            emit = 1'b0;
        end
        else if (!e_in_pixel)
        begin
            is_run_next   = q_entry.is_run;
            left_next     = q_entry.count;
            in_pixel_next = 1'b1;
            slot_next     = '0;
        end
        else if (e_slot < last_slot)
        begin
            case (e_slot)
                2'd0:    blue_next  = b;
                2'd1:    green_next = b;
                default: red_next   = b;
            endcase
            slot_next = e_slot + 2'd1;
        end
        else
        begin
            emit      = 1'b1;
            pix_alpha = four ? b : '0;
            if (!four && e_slot == SLOT_RED)
            begin
                pix_red = b;
            end
            red_next  = pix_red;
            slot_next = '0;
            if (e_is_run)
            begin
                rep       = clamp ? remaining[BYTE_W-1:0] : e_left;
                trunc     = clamp;
                left_next = '0;
            end
            else
            begin
                rep       = 8'd1;
                left_next = e_left - 8'd1;
            end
            done_next     = e_done + {{(TOTAL_W-BYTE_W){1'b0}}, rep};
            in_pixel_next = (left_next != '0);
        end

        out_valid_next = out_valid_reg;
        if (q_pop && emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (pix_out.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_pixel_reg  <= 1'b0;
            is_run_reg    <= 1'b0;
            left_reg      <= '0;
            slot_reg      <= '0;
            blue_reg      <= '0;
            green_reg     <= '0;
            red_reg       <= '0;
            done_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                in_pixel_reg <= in_pixel_next;
                is_run_reg   <= is_run_next;
                left_reg     <= left_next;
                slot_reg     <= slot_next;
                blue_reg     <= blue_next;
                green_reg    <= green_next;
                red_reg      <= red_next;
                done_reg     <= done_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            o_red_reg   <= pix_red;
            o_green_reg <= e_green;
            o_blue_reg  <= e_blue;
            o_alpha_reg <= pix_alpha;
            o_rep_reg   <= rep;
            o_done_reg  <= (done_next >= total);
            o_trunc_reg <= trunc;
        end
    end

    assign pix_out.valid      = out_valid_reg;
    assign pix_out.red        = o_red_reg;
    assign pix_out.green      = o_green_reg;
    assign pix_out.blue       = o_blue_reg;
    assign pix_out.alpha      = o_alpha_reg;
    assign pix_out.repeat_res = o_rep_reg;
    assign pix_out.image_done = o_done_reg;
    assign pix_out.truncated  = o_trunc_reg;

endmodule

`default_nettype wire

FILE: hw/rtl/tga_rle_pixel_decoder.sv
// ============================================================================
// tga_rle_pixel_decoder
// Targa run-length pixel stream decoder with an APB configuration port.
// ============================================================================
//
//   Channel   Direction  Beat content
//   byte_in   in         data_byte, frame_start
//   pix_out   out        red, green, blue, alpha, repeat_res, image_done, truncated
//   APB       in/out     bytes_per_pixel at 0x0, pixel_total at 0x4
//
// One byte is taken every cycle while the output is not stalled; a pixel
// result reaches pix_out through the byte queue and the output register.
// Reset clears the queue, the decode state and the output valid, and sets
// bytes_per_pixel to 3 and pixel_total to 1.
// A stalled output holds the decode stage; the two-entry byte queue keeps
// byte_in ready until it is full.
//
`timescale 1ns / 1ps
`default_nettype none

module tga_rle_pixel_decoder (
    input  wire                                clk,
    input  wire                                rst_n,
    tga_rle_byte_if.sink                       byte_in,
    tga_rle_pix_if.source                      pix_out,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [tga_rle_pkg::ADDR_W-1:0]      paddr,
    input  wire [tga_rle_pkg::DATA_W-1:0]      pwdata,
    output logic [tga_rle_pkg::DATA_W-1:0]     prdata,
    output logic                               pready
);
    import tga_rle_pkg::*;

    logic [BPP_W-1:0]   bpp_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               cfg_wr;
    tga_rle_reg_t       reg_sel;
    logic               q_valid;
    tga_rle_entry_t     q_entry;
    logic               q_pop;

    assign pready  = 1'b1;
    assign reg_sel = tga_rle_reg_t'(paddr[2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bpp_reg   <= BPP_RESET;
            total_reg <= TOTAL_RESET;
        end
        else if (cfg_wr)
        begin
            case (reg_sel)
                REG_BYTES_PER_PIXEL: bpp_reg   <= pwdata[BPP_W-1:0];
                REG_PIXEL_TOTAL:     total_reg <= pwdata[TOTAL_W-1:0];
                default:             bpp_reg   <= bpp_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_sel)
            REG_BYTES_PER_PIXEL: prdata = {{(DATA_W-BPP_W){1'b0}}, bpp_reg};
            REG_PIXEL_TOTAL:     prdata = {{(DATA_W-TOTAL_W){1'b0}}, total_reg};
            default:             prdata = '0;
        endcase
    end

    tga_rle_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_in),
        .q_valid (q_valid),
        .q_entry (q_entry),
        .q_pop   (q_pop)
    );

    tga_rle_back u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_entry         (q_entry),
        .q_pop           (q_pop),
        .bytes_per_pixel (bpp_reg),
        .pixel_total     (total_reg),
        .pix_out         (pix_out)
    );

    a_rep_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid |-> pix_out.repeat_res != '0)
        else $error("pixel beat with zero repeat count");

    a_trunc_done: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && pix_out.truncated |-> pix_out.image_done)
        else $error("clamped run did not complete the image");

    a_alpha_bgr: assert property (@(posedge clk) disable iff (!rst_n)
        pix_out.valid && bpp_reg != BPP_ALPHA |-> pix_out.alpha == '0)
        else $error("nonzero alpha on a three-byte pixel");

    a_pop_space: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !pix_out.valid || pix_out.ready)
        else $error("decode stage advanced into a full output register");

endmodule

`default_nettype wire

FILE: test/tb_tga_rle_pixel_decoder.sv
// ============================================================================
// tb_tga_rle_pixel_decoder
// Self-checking testbench for the Targa run-length pixel decoder.
// A short table of directed bytes and register writes covers reset values,
// field extremes, clamped runs, cut-off literal packets, a zero pixel total
// and a change of pixel size in the middle of a pixel. Random phases follow,
// each possibly with new register values and a byte stream shaped by the decoder
// state. Every accepted byte goes through a behavioral decoder in the bench,
// and each pixel beat is compared field by field with the oldest pixel due.
// ============================================================================
`timescale 1ns / 1ps

module tb_tga_rle_pixel_decoder;

    import tga_rle_pkg::*;

    localparam int CYCLE_LIMIT  = 500000;
    localparam int DRAIN_CYCLES = 10;
    localparam int LONG_HOLD    = 80;
    localparam int PHASES       = 13;
    localparam int DIR_ROWS     = 36;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [7:0] repeat_res;
        logic       image_done;
        logic       truncated;
    } pixel_t;

    typedef enum logic [1:0] {
        ROW_BYTE,
        ROW_SET_BPP,
        ROW_SET_TOTAL
    } row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [31:0] value;
        logic        frame_start;
        logic        typed;
        pixel_t      pix;
    } stim_row_t;

    localparam pixel_t NO_PIX = '0;

    localparam stim_row_t DIR_TABLE [DIR_ROWS] = '{
        '{ROW_BYTE,      32'h00,      1'b1, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h00,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'hFF,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h80,      1'b0, 1'b1,
          '{8'h80, 8'hFF, 8'h00, 8'h00, 8'd1, 1'b1, 1'b0}},
        '{ROW_BYTE,      32'hAA,      1'b0, 1'b0, NO_PIX},
        '{ROW_SET_TOTAL, 32'h1FFFFFF, 1'b0, 1'b0, NO_PIX},
        '{ROW_SET_BPP,   32'd4,       1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'hFF,      1'b1, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h12,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h34,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h56,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h78,      1'b0, 1'b1,
          '{8'h56, 8'h34, 8'h12, 8'h78, 8'd128, 1'b0, 1'b0}},
        '{ROW_SET_TOTAL, 32'd3,       1'b0, 1'b0, NO_PIX},
        '{ROW_SET_BPP,   32'd3,       1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h80,      1'b1, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'hC0,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'hFF,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h01,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h7F,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h10,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h20,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h30,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h40,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h50,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h60,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h99,      1'b0, 1'b0, NO_PIX},
        '{ROW_SET_TOTAL, 32'd0,       1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h3C,      1'b1, 1'b0, NO_PIX},
        '{ROW_SET_TOTAL, 32'd5,       1'b0, 1'b0, NO_PIX},
        '{ROW_SET_BPP,   32'd4,       1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h8A,      1'b1, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h01,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h02,      1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'h03,      1'b0, 1'b0, NO_PIX},
        '{ROW_SET_BPP,   32'd0,       1'b0, 1'b0, NO_PIX},
        '{ROW_BYTE,      32'hEE,      1'b0, 1'b1,
          '{8'h03, 8'h02, 8'h01, 8'h00, 8'd5, 1'b1, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    tga_rle_byte_if byte_ch ();
    tga_rle_pix_if  pix_ch ();

    tga_rle_pixel_decoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .byte_in (byte_ch),
        .pix_out (pix_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [BPP_W-1:0]   cfg_bpp;
    logic [TOTAL_W-1:0] cfg_total;
    logic               st_in_pixel;
    logic               st_is_run;
    logic [7:0]         st_left;
    logic [SLOT_W-1:0]  st_slot;
    logic [7:0]         st_blue;
    logic [7:0]         st_green;
    logic [7:0]         st_red;
    logic [TOTAL_W-1:0] st_done;

    pixel_t pixels_due [$];
    int     errors = 0;
    int     cycle_count = 0;
    bit     send_gaps = 1'b0;
    bit     recv_gaps = 1'b0;
    bit     long_hold_req = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [TOTAL_W-1:0] pixel_limit();
        return (cfg_total > MAX_PIXELS) ? MAX_PIXELS : cfg_total;
    endfunction

    function automatic bit image_complete();
        return st_done >= pixel_limit();
    endfunction

    function automatic bit decode_byte(input logic [7:0] b, input logic fs,
                                       output bit used, output pixel_t px);
        logic [TOTAL_W-1:0] lim;
        logic [TOTAL_W-1:0] rep;
        logic [SLOT_W-1:0]  end_slot;
        logic [7:0]         alpha_v;
        bit                 four;
        bit                 clamp;
        px = '0;
        used = 1'b0;
        if (fs)
        begin
            st_in_pixel = 1'b0;
            st_is_run   = 1'b0;
            st_left     = '0;
            st_slot     = '0;
            st_blue     = '0;
            st_green    = '0;
            st_red      = '0;
            st_done     = '0;
        end
        lim = pixel_limit();
        if (st_done >= lim)
            return 1'b0;
        used = 1'b1;
        if (!st_in_pixel)
        begin
            st_is_run   = (b >= 8'd128);
            st_left     = st_is_run ? b - RUN_BIAS : b + 8'd1;
            st_in_pixel = 1'b1;
            st_slot     = '0;
            return 1'b0;
        end
        four = (cfg_bpp == BPP_ALPHA);
        end_slot = four ? SLOT_ALPHA : SLOT_RED;
        if (st_slot < end_slot)
        begin
            case (st_slot)
                2'd0:    st_blue = b;
                2'd1:    st_green = b;
                default: st_red = b;
            endcase
            st_slot = st_slot + 2'd1;
            return 1'b0;
        end
        alpha_v = four ? b : 8'd0;
        if (!four && st_slot == SLOT_RED)
            st_red = b;
        st_slot = '0;
        clamp = 1'b0;
        if (st_is_run)
        begin
            rep = TOTAL_W'(st_left);
            if (rep > lim - st_done)
            begin
                rep = lim - st_done;
                clamp = 1'b1;
            end
            st_left = '0;
        end
        else
        begin
            rep = TOTAL_W'(1);
            st_left = st_left - 8'd1;
        end
        st_done = st_done + rep;
        if (st_left == 0)
            st_in_pixel = 1'b0;
        px = '{st_red, st_green, st_blue, alpha_v, rep[7:0], st_done >= lim, clamp};
        return 1'b1;
    endfunction

    task automatic reg_write(input tga_rle_reg_t idx, input logic [31:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_BYTES_PER_PIXEL)
            cfg_bpp = value[BPP_W-1:0];
        else
            cfg_total = value[TOTAL_W-1:0];
    endtask

    task automatic settle();
        byte_ch.valid <= 1'b0;
        while (pixels_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_byte(input logic [7:0] data, input logic fs, input logic typed,
                             input pixel_t typed_pix, output bit used);
        pixel_t px;
        if (send_gaps && $urandom_range(0, 5) == 0)
        begin
            byte_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_ch.valid       <= 1'b1;
        byte_ch.data_byte   <= data;
        byte_ch.frame_start <= fs;
        do
            @(posedge clk);
        while (!byte_ch.ready);
        if (decode_byte(data, fs, used, px))
            pixels_due.push_back(typed ? typed_pix : px);
    endtask

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        pixel_t got;
        pixel_t want;
        if (rst_n && pix_ch.valid && pix_ch.ready)
        begin
            got = '{pix_ch.red, pix_ch.green, pix_ch.blue, pix_ch.alpha,
                    pix_ch.repeat_res, pix_ch.image_done, pix_ch.truncated};
            if (pixels_due.size() == 0)
            begin
                $display("%0t: pixel beat with none due, expected nothing, got %h",
                         $time, got);
                errors++;
            end
            else
            begin
                want = pixels_due.pop_front();
                check_field("red", want.red, got.red);
                check_field("green", want.green, got.green);
                check_field("blue", want.blue, got.blue);
                check_field("alpha", want.alpha, got.alpha);
                check_field("repeat_res", want.repeat_res, got.repeat_res);
                check_field("image_done", want.image_done, got.image_done);
                check_field("truncated", want.truncated, got.truncated);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int stall_left;
        stall_left = 0;
        pix_ch.ready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                stall_left--;
                pix_ch.ready <= 1'b0;
            end
            else
            begin
                pix_ch.ready <= 1'b1;
                if (long_hold_req)
                begin
                    long_hold_req = 1'b0;
                    stall_left = LONG_HOLD;
                end
                else if (recv_gaps && $urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 14);
            end
        end
    end

    initial
    begin
        bit          used;
        bit          last_part;
        logic        fs;
        logic [7:0]  data;
        logic [31:0] value;
        int          budget;
        int          used_n;
        int          sent;

        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_ch.valid = 1'b0;
        byte_ch.data_byte = '0;
        byte_ch.frame_start = 1'b0;
        cfg_bpp = BPP_RESET;
        cfg_total = TOTAL_RESET;
        st_in_pixel = 1'b0;
        st_is_run = 1'b0;
        st_left = '0;
        st_slot = '0;
        st_blue = '0;
        st_green = '0;
        st_red = '0;
        st_done = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_ROWS; i++)
        begin
            case (DIR_TABLE[i].kind)
                ROW_SET_BPP:
                begin
                    settle();
                    reg_write(REG_BYTES_PER_PIXEL, DIR_TABLE[i].value);
                end
                ROW_SET_TOTAL:
                begin
                    settle();
                    reg_write(REG_PIXEL_TOTAL, DIR_TABLE[i].value);
                end
                default:
                    send_byte(DIR_TABLE[i].value[7:0], DIR_TABLE[i].frame_start,
                              DIR_TABLE[i].typed, DIR_TABLE[i].pix, used);
            endcase
        end

        for (int phase = 0; phase < PHASES; phase++)
        begin
            last_part = (phase >= PHASES - 2);
            settle();
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: value = 32'(BPP_RESET);
                    4, 5, 6, 7: value = 32'(BPP_ALPHA);
                    default:    value = $urandom_range(0, 7);
                endcase
                reg_write(REG_BYTES_PER_PIXEL, value);
            end
            if (phase == 0 || $urandom_range(0, 2) != 0)
            begin
                case ($urandom_range(0, 19))
                    0:       value = 32'd0;
                    1:       value = 32'h1FFFFFF;
                    2:       value = 32'(MAX_PIXELS) - $urandom_range(0, 1);
                    3:       value = $urandom_range(1, 32'h1FFFFFF);
                    default: value = $urandom_range(1, 200);
                endcase
                reg_write(REG_PIXEL_TOTAL, value);
            end
            send_gaps = !last_part && $urandom_range(0, 3) != 0;
            recv_gaps = !last_part && $urandom_range(0, 3) != 0;
            if (phase == 3)
            begin
                send_gaps = 1'b0;
                long_hold_req = 1'b1;
            end
            budget = $urandom_range(100, 150);
            used_n = 0;
            sent = 0;
            while (used_n < budget && sent < budget + 40)
            begin
                if (sent == 0)
                    fs = ($urandom_range(0, 3) != 0);
                else if (image_complete())
                    fs = ($urandom_range(0, 3) != 0);
                else
                    fs = ($urandom_range(0, 60) == 0);
                if (fs || !st_in_pixel)
                begin
                    case ($urandom_range(0, 3))
                        0:       data = 8'($urandom_range(0, 7));
                        1:       data = 8'($urandom_range(128, 143));
                        default: data = 8'($urandom);
                    endcase
                end
                else
                    data = 8'($urandom);
                send_byte(data, fs, 1'b0, NO_PIX, used);
                if (used)
                    used_n++;
                sent++;
            end
        end

        send_gaps = 1'b0;
        recv_gaps = 1'b0;
        settle();
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
